// File: rtl/core/msd_pkg.sv
package msd_pkg;

    // Fixed widths of the request and result fields.
    localparam int SAMPLE_BITS = 24;
    localparam int STD_BITS    = 24;
    localparam int STATUS_BITS = 2;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd2;

    // One incoming sample of a data set.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_req;

    // One result per data set.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean_value;
        logic [STD_BITS-1:0]           std_dev;
        logic [STATUS_BITS-1:0]        status;
    } t_res;

endpackage

// File: rtl/core/mean_and_sample_std_dev.sv
// Mean and sample standard deviation of a data set of signed Q12.12 samples.
// Input channel (i_req_valid / o_req_ready / i_req): one sample per request,
// with last set on the final sample of the set. Samples are taken one per
// cycle while the block is loading and are written into an on-chip store.
// Samples beyond MAX_SAMPLES are dropped and the result reports overflow.
//
// Output channel (o_rsp_valid / i_rsp_ready / o_rsp): one result per set,
// holding the mean (truncated toward zero), floor(sqrt(sum_sq / (n - 1)))
// and a status code. A set of one sample reports too-few with std_dev 0.
//
// The divider works on DW = 2 * SAMPLE_WIDTH + 2 + clog2(MAX_SAMPLES + 1)
// bits, rounded up to even. The time from the last request to the result is
// spent in the second read pass over the sample store, one shared
// one-bit-per-cycle divider used twice, and a two-bits-per-cycle square root.
// No request is taken from the last sample until the result is queued.
//
// The result sits in an output register; loading of the next set may begin
// while it waits for i_rsp_ready. A new result waits until that register is
// free. Reset clears the count, sums and flags; the store needs no clearing.
module mean_and_sample_std_dev #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  msd_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output msd_pkg::t_res o_rsp
);
    import msd_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int SUMW = SW + CW;
    localparam int SQBW = 2 * (SW + 1);
    localparam int SQW  = SQBW + CW;
    localparam int DW   = SQW + (SQW % 2);
    localparam int RW   = DW / 2;
    localparam int IW   = $clog2(DW + 1);
    localparam int XW   = RW + STD_BITS;

    // Sequencer codes.
    localparam logic [2:0] S_LOAD     = 3'd0;
    localparam logic [2:0] S_MEAN_SET = 3'd1;
    localparam logic [2:0] S_MEAN_DIV = 3'd2;
    localparam logic [2:0] S_MEAN_FIX = 3'd3;
    localparam logic [2:0] S_PASS     = 3'd4;
    localparam logic [2:0] S_VAR_SET  = 3'd5;
    localparam logic [2:0] S_VAR_DIV  = 3'd6;
    localparam logic [2:0] S_SQRT     = 3'd7;

    logic [2:0]            r_state, n_state;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_count, n_count;
    logic signed [SUMW-1:0] r_sum, n_sum;
    logic                  r_ovf, n_ovf;
    logic [SQW-1:0]        r_sq_sum, n_sq_sum;
    logic                  r_sum_neg, n_sum_neg;
    logic [DW-1:0]         r_div_num, n_div_num;
    logic [CW-1:0]         r_div_rem, n_div_rem;
    logic [CW-1:0]         r_div_den, n_div_den;
    logic [IW-1:0]         r_iter, n_iter;
    logic signed [SW-1:0]  r_mean, n_mean;
    logic [CW-1:0]         r_rd_addr, n_rd_addr;
    logic                  r_rd_vld, r_abs_vld, r_sq_vld;
    logic signed [SW-1:0]  r_rd_data;
    logic [SW:0]           r_abs;
    logic [SQBW-1:0]       r_sq;
    logic [RW-1:0]         r_root, n_root;
    logic [RW+1:0]         r_srem, n_srem;
    logic [STD_BITS-1:0]   r_sd, n_sd;
    logic                  r_res_valid, n_res_valid;
    t_res                  r_res, n_res;

    logic signed [SW-1:0]  mem [MAX_SAMPLES];

    logic                  w_accept;
    logic                  w_has_room;
    logic signed [SW-1:0]  w_x;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic signed [SW:0]    w_diff;
    logic [CW:0]           w_div_sh;
    logic                  w_div_bit;
    logic [RW+3:0]         w_sq_sh;
    logic [RW+3:0]         w_sq_trial;
    logic                  w_sq_bit;
    logic [XW-1:0]         w_root_ext;
    logic [SW-1:0]         w_quot;
    logic                  w_res_load;

    // Handshake and sample intake.
    assign o_req_ready = (r_state == S_LOAD) && !r_done;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_has_room  = r_count < CW'(MAX_SAMPLES);
    assign w_x         = $signed(i_req.sample[SW-1:0]);
    assign w_wr_en     = w_accept && w_has_room;
    assign w_rd_en     = (r_state == S_PASS) && !r_done && (r_rd_addr < r_count);

    // Deviation of the sample read back from the mean.
    assign w_diff = (SW+1)'(r_rd_data) - (SW+1)'(r_mean);

    // One restoring divider step.
    assign w_div_sh  = {r_div_rem, r_div_num[DW-1]};
    assign w_div_bit = w_div_sh >= {1'b0, r_div_den};

    // One square root step: bring down two bits and try root*4+1.
    assign w_sq_sh    = {r_srem, r_div_num[DW-1:DW-2]};
    assign w_sq_trial = (RW+4)'({r_root, 2'b01});
    assign w_sq_bit   = w_sq_sh >= w_sq_trial;

    // Root after the current square root step.
    assign w_root_ext = XW'({r_root[RW-2:0], w_sq_bit});
    assign w_quot     = r_div_num[SW-1:0];
    assign w_res_load = r_done && (!r_res_valid || i_rsp_ready);

    // Sequencer and shared arithmetic.
    always_comb begin
        n_state     = r_state;
        n_done      = r_done;
        n_count     = r_count;
        n_sum       = r_sum;
        n_ovf       = r_ovf;
        n_sq_sum    = r_sq_sum;
        n_sum_neg   = r_sum_neg;
        n_div_num   = r_div_num;
        n_div_rem   = r_div_rem;
        n_div_den   = r_div_den;
        n_iter      = r_iter;
        n_mean      = r_mean;
        n_rd_addr   = r_rd_addr;
        n_root      = r_root;
        n_srem      = r_srem;
        n_sd        = r_sd;
        n_res_valid = r_res_valid;
        n_res       = r_res;

        if (r_res_valid && i_rsp_ready) begin
            n_res_valid = 1'b0;
        end

        if (r_done) begin
            // Queue the result and clear the set.
            if (w_res_load) begin
                n_res_valid      = 1'b1;
                n_res.mean_value = SAMPLE_BITS'(r_mean);
                n_res.std_dev    = r_sd;
                if (r_ovf) begin
                    n_res.status = ST_OVERFLOW;
                end else if (r_count < CW'(2)) begin
                    n_res.status = ST_TOO_FEW;
                end else begin
                    n_res.status = ST_OK;
                end
                n_done   = 1'b0;
                n_state  = S_LOAD;
                n_count  = '0;
                n_sum    = '0;
                n_ovf    = 1'b0;
                n_sq_sum = '0;
            end
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_has_room) begin
                            n_count = r_count + CW'(1);
                            n_sum   = r_sum + SUMW'(w_x);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_req.last) begin
                            n_state = S_MEAN_SET;
                        end
                    end
                end
                S_MEAN_SET: begin
                    n_sum_neg = r_sum[SUMW-1];
                    n_div_num = r_sum[SUMW-1] ? DW'(-r_sum) : DW'(r_sum);
                    n_div_rem = '0;
                    n_div_den = r_count;
                    n_iter    = IW'(DW);
                    n_state   = S_MEAN_DIV;
                end
                S_MEAN_DIV, S_VAR_DIV: begin
                    n_div_num = {r_div_num[DW-2:0], w_div_bit};
                    n_div_rem = w_div_bit ? CW'(w_div_sh - {1'b0, r_div_den})
                                          : w_div_sh[CW-1:0];
                    n_iter    = r_iter - IW'(1);
                    if (r_iter == IW'(1)) begin
                        if (r_state == S_MEAN_DIV) begin
                            n_state = S_MEAN_FIX;
                        end else begin
                            n_root  = '0;
                            n_srem  = '0;
                            n_iter  = IW'(RW);
                            n_state = S_SQRT;
                        end
                    end
                end
                S_MEAN_FIX: begin
                    n_mean    = r_sum_neg ? $signed(-w_quot) : $signed(w_quot);
                    n_rd_addr = '0;
                    n_sq_sum  = '0;
                    n_state   = S_PASS;
                end
                S_PASS: begin
                    if (w_rd_en) begin
                        n_rd_addr = r_rd_addr + CW'(1);
                    end
                    if (r_sq_vld) begin
                        n_sq_sum = r_sq_sum + SQW'(r_sq);
                    end
                    if (!w_rd_en && !r_rd_vld && !r_abs_vld && !r_sq_vld) begin
                        n_state = S_VAR_SET;
                    end
                end
                S_VAR_SET: begin
                    if (r_count < CW'(2)) begin
                        n_sd   = '0;
                        n_done = 1'b1;
                    end else begin
                        n_div_num = DW'(r_sq_sum);
                        n_div_rem = '0;
                        n_div_den = r_count - CW'(1);
                        n_iter    = IW'(DW);
                        n_state   = S_VAR_DIV;
                    end
                end
                S_SQRT: begin
                    n_div_num = {r_div_num[DW-3:0], 2'b00};
                    n_root    = {r_root[RW-2:0], w_sq_bit};
                    n_srem    = w_sq_bit ? (RW+2)'(w_sq_sh - w_sq_trial)
                                         : w_sq_sh[RW+1:0];
                    n_iter    = r_iter - IW'(1);
                    if (r_iter == IW'(1)) begin
                        n_done = 1'b1;
                        // Clamp the final root to the field width.
                        if (w_root_ext > XW'({STD_BITS{1'b1}})) begin
                            n_sd = '1;
                        end else begin
                            n_sd = w_root_ext[STD_BITS-1:0];
                        end
                    end
                end
                default: begin
                    n_state = S_LOAD;
                end
            endcase
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_sq_sum    <= '0;
            r_rd_addr   <= '0;
            r_rd_vld    <= 1'b0;
            r_abs_vld   <= 1'b0;
            r_sq_vld    <= 1'b0;
            r_res_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_ovf       <= n_ovf;
            r_sq_sum    <= n_sq_sum;
            r_rd_addr   <= n_rd_addr;
            r_rd_vld    <= w_rd_en;
            r_abs_vld   <= r_rd_vld;
            r_sq_vld    <= r_abs_vld;
            r_res_valid <= n_res_valid;
            r_iter      <= n_iter;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_sum_neg <= n_sum_neg;
        r_div_num <= n_div_num;
        r_div_rem <= n_div_rem;
        r_div_den <= n_div_den;
        r_mean    <= n_mean;
        r_root    <= n_root;
        r_srem    <= n_srem;
        r_sd      <= n_sd;
        r_res     <= n_res;
        r_abs     <= w_diff[SW] ? $unsigned(-w_diff) : $unsigned(w_diff);
        r_sq      <= SQBW'(r_abs) * SQBW'(r_abs);
    end

    // Sample store: written while loading, read back during the second pass.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_count[AW-1:0]] <= w_x;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_rd_addr[AW-1:0]];
        end
    end

    assign o_rsp_valid = r_res_valid;
    assign o_rsp       = r_res;

    // A closing sample always starts the mean division.
    a_last_starts_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.last) |=> (r_state == S_MEAN_SET))
        else $error("last sample did not start the mean division");

    // The read pass never runs past the stored samples.
    a_pass_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |-> (r_rd_addr <= r_count && r_count <= CW'(MAX_SAMPLES)))
        else $error("second pass address beyond stored count");

    // Queuing a result clears the set and shows the result.
    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |=> (o_rsp_valid && r_count == '0 && !r_ovf && !r_done))
        else $error("result queued without clearing the set");

    // A too-few result carries a zero deviation.
    a_too_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == ST_TOO_FEW) |-> (o_rsp.std_dev == '0))
        else $error("too-few result with nonzero deviation");

endmodule
